[rtl/mwsc_pkg.sv]
// Shared widths and pipeline payload types for the mecanum wheel speed controller.
`default_nettype none
package mwsc_pkg;
	localparam int WHEEL_COUNT = 4;
	localparam int STICK_W     = 11;
	localparam int SPEED_W     = 16;
	localparam int CUR_W       = 16;
	localparam int PROD_W      = 28;                 // stick times gain, signed
	localparam int REF_W       = 29;                 // sum of three products, signed
	localparam int MAG_W       = REF_W - 1;          // reference magnitude
	localparam int Q_W         = 23;                 // wheel limit << 8, and the quotient
	localparam int DVD_W       = MAG_W + Q_W;        // magnitude times limit
	localparam int ERR_W       = REF_W + 1;          // speed error, signed
	localparam int AERR_W      = ERR_W - 1;
	localparam int PG_W        = 16;
	localparam int PE_W        = AERR_W + PG_W;
	localparam int IN_W        = 104;
	localparam int OUT_W       = 136;
	localparam int ADDR_W      = 3;
	localparam int CFG_W       = 16;

	typedef enum logic [ADDR_W-1:0] {
		REG_DEADZONE      = 3'd0,
		REG_CHANNEL_LIMIT = 3'd1,
		REG_LINEAR_GAIN   = 3'd2,
		REG_SPIN_GAIN     = 3'd3,
		REG_WHEEL_LIMIT   = 3'd4,
		REG_PROP_GAIN     = 3'd5,
		REG_CURRENT_LIMIT = 3'd6
	} reg_idx_t;

	// One beat as it walks through the divider stages.
	typedef struct packed {
		logic                                ok;
		logic                                scale;
		logic [MAG_W-1:0]                    top;
		logic [WHEEL_COUNT-1:0]              neg;
		logic [WHEEL_COUNT-1:0][MAG_W-1:0]   mag;
		logic [WHEEL_COUNT-1:0][SPEED_W-1:0] meas;
		logic [WHEEL_COUNT-1:0][DVD_W-1:0]   dvd;
		logic [WHEEL_COUNT-1:0][MAG_W-1:0]   rem;
		logic [WHEEL_COUNT-1:0][Q_W-1:0]     quot;
	} div_t;
endpackage
`default_nettype wire

[rtl/mecanum_wheel_speed_controller.sv]
// Mecanum wheel speed controller: deadzone, kinematics, scaling divider, P loop.
// Throughput: one beat per cycle; the whole pipe advances whenever the
// output register is empty or being taken, so a stall freezes every stage.
// The 23 one-bit-per-stage divider stages make up most of the pipeline depth.
// Reset (arst_n low): valid bits clear, configuration registers return to their defaults.
`default_nettype none
module mecanum_wheel_speed_controller (
	input  wire                         clk,
	input  wire                         arst_n,
	// enabled, remote_ready, feedback_fresh, stick_forward, stick_strafe,
	// stick_spin, speed_right_front, speed_left_front, speed_left_back,
	// speed_right_back, zero pad
	input  wire [mwsc_pkg::IN_W-1:0]    s_tdata,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	// current_right_front, current_left_front, current_left_back,
	// current_right_back, command_frame, safe_stop, zero pad
	output logic [mwsc_pkg::OUT_W-1:0]  m_tdata,
	output logic                        m_tvalid,
	input  wire                         m_tready,
	input  wire                         cfg_we,
	input  wire [mwsc_pkg::ADDR_W-1:0]  cfg_addr,
	input  wire [mwsc_pkg::CFG_W-1:0]   cfg_wdata
);
	import mwsc_pkg::*;

	// ---------------- configuration registers ----------------
	logic [7:0]  deadzone_q;
	logic [9:0]  chan_lim_q;
	logic [15:0] lin_gain_q;
	logic [15:0] spin_gain_q;
	logic [14:0] wheel_lim_q;
	logic [15:0] prop_gain_q;
	logic [14:0] cur_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q  <= 8'd10;
			chan_lim_q  <= 10'd660;
			lin_gain_q  <= 16'd925;
			spin_gain_q <= 16'd685;
			wheel_lim_q <= 15'd9000;
			prop_gain_q <= 16'd2560;
			cur_lim_q   <= 15'd16384;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_DEADZONE:      deadzone_q  <= cfg_wdata[7:0];
				REG_CHANNEL_LIMIT: chan_lim_q  <= cfg_wdata[9:0];
				REG_LINEAR_GAIN:   lin_gain_q  <= cfg_wdata;
				REG_SPIN_GAIN:     spin_gain_q <= cfg_wdata;
				REG_WHEEL_LIMIT:   wheel_lim_q <= cfg_wdata[14:0];
				REG_PROP_GAIN:     prop_gain_q <= cfg_wdata;
				REG_CURRENT_LIMIT: cur_lim_q   <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// Global advance: the output register is the only place a beat can wait.
	logic ce;
	assign ce       = !m_tvalid || m_tready;
	assign s_tready = ce;

	// Deadzone then symmetric clamp of one stick channel.
	function automatic logic signed [STICK_W-1:0] shape(
		input logic signed [STICK_W-1:0] c,
		input logic [7:0] dz,
		input logic [9:0] lim
	);
		logic signed [STICK_W:0] cx, dzx, limx;
		cx   = (STICK_W+1)'(c);
		dzx  = $signed({4'b0, dz});
		limx = $signed({2'b0, lim});
		if (cx > -dzx && cx < dzx)
			cx = '0;
		if (cx > limx)
			cx = limx;
		if (cx < -limx)
			cx = -limx;
		return STICK_W'(cx);
	endfunction

	// ---------------- s1: flags, stick shaping ----------------
	logic                      v_s1, ok_s1;
	logic signed [STICK_W-1:0] f_s1, st_s1, w_s1;
	logic [WHEEL_COUNT-1:0][SPEED_W-1:0] meas_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (ce)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ok_s1   <= s_tdata[0] & s_tdata[1] & s_tdata[2];
			f_s1    <= shape(s_tdata[13:3],  deadzone_q, chan_lim_q);
			st_s1   <= shape(s_tdata[24:14], deadzone_q, chan_lim_q);
			w_s1    <= shape(s_tdata[35:25], deadzone_q, chan_lim_q);
			meas_s1 <= s_tdata[99:36];
		end
	end

	// ---------------- s2: gain products ----------------
	logic                     v_s2, ok_s2;
	logic signed [PROD_W-1:0] lf_s2, ls_s2, rw_s2;
	logic [WHEEL_COUNT-1:0][SPEED_W-1:0] meas_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (ce)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ok_s2   <= ok_s1;
			lf_s2   <= PROD_W'(f_s1)  * PROD_W'($signed({1'b0, lin_gain_q}));
			ls_s2   <= PROD_W'(st_s1) * PROD_W'($signed({1'b0, lin_gain_q}));
			rw_s2   <= PROD_W'(w_s1)  * PROD_W'($signed({1'b0, spin_gain_q}));
			meas_s2 <= meas_s1;
		end
	end

	// ---------------- s3: wheel references (Q21.8 rpm, sign included) ----------------
	logic                    v_s3, ok_s3;
	logic signed [REF_W-1:0] ref_s3 [WHEEL_COUNT];
	logic [WHEEL_COUNT-1:0][SPEED_W-1:0] meas_s3;
	logic signed [REF_W-1:0] lfx, lsx, rwx;

	assign lfx = REF_W'(lf_s2);
	assign lsx = REF_W'(ls_s2);
	assign rwx = REF_W'(rw_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (ce)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ok_s3     <= ok_s2;
			ref_s3[0] <= -lfx + lsx + rwx;   // right front
			ref_s3[1] <=  lfx + lsx + rwx;   // left front
			ref_s3[2] <=  lfx - lsx + rwx;   // left back
			ref_s3[3] <= -lfx - lsx + rwx;   // right back
			meas_s3   <= meas_s2;
		end
	end

	// ---------------- s4: magnitudes, first max level ----------------
	logic                   v_s4, ok_s4;
	logic [WHEEL_COUNT-1:0] neg_s4;
	logic [WHEEL_COUNT-1:0][MAG_W-1:0]   mag_s4;
	logic [MAG_W-1:0]       m01_s4, m23_s4;
	logic [WHEEL_COUNT-1:0][SPEED_W-1:0] meas_s4;
	logic [MAG_W-1:0]       mag_c [WHEEL_COUNT];

	always_comb begin
		for (int i = 0; i < WHEEL_COUNT; i++)
			mag_c[i] = ref_s3[i][REF_W-1] ? MAG_W'(-ref_s3[i]) : MAG_W'(ref_s3[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (ce)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ok_s4 <= ok_s3;
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				neg_s4[i] <= ref_s3[i][REF_W-1];
				mag_s4[i] <= mag_c[i];
			end
			m01_s4  <= (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
			m23_s4  <= (mag_c[2] > mag_c[3]) ? mag_c[2] : mag_c[3];
			meas_s4 <= meas_s3;
		end
	end

	// ---------------- s5: largest magnitude, scale decision ----------------
	logic                   v_s5, ok_s5, scale_s5;
	logic [MAG_W-1:0]       top_s5;
	logic [WHEEL_COUNT-1:0] neg_s5;
	logic [WHEEL_COUNT-1:0][MAG_W-1:0]   mag_s5;
	logic [WHEEL_COUNT-1:0][SPEED_W-1:0] meas_s5;
	logic [Q_W-1:0]         lim_q8;
	logic [MAG_W-1:0]       top_c;

	assign lim_q8 = {wheel_lim_q, 8'b0};
	assign top_c  = (m01_s4 > m23_s4) ? m01_s4 : m23_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (ce)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ok_s5    <= ok_s4;
			top_s5   <= top_c;
			scale_s5 <= top_c > MAG_W'(lim_q8);
			neg_s5   <= neg_s4;
			mag_s5   <= mag_s4;
			meas_s5  <= meas_s4;
		end
	end

	// ---------------- s6: dividend = |ref| * limit, into divider ----------------
	// dv_s[0] is the s6 register; dv_s[k+1] is after divider stage k, which sets quotient bit Q_W-1-k.
	div_t                 dv_s  [Q_W+1];
	logic [Q_W:0]         dv_v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v_s[0] <= 1'b0;
		else if (ce)
			dv_v_s[0] <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			dv_s[0].ok    <= ok_s5;
			dv_s[0].scale <= scale_s5;
			dv_s[0].top   <= top_s5;
			dv_s[0].neg   <= neg_s5;
			dv_s[0].mag   <= mag_s5;
			dv_s[0].meas  <= meas_s5;
			dv_s[0].rem   <= '0;
			dv_s[0].quot  <= '0;
			for (int i = 0; i < WHEEL_COUNT; i++)
				dv_s[0].dvd[i] <= DVD_W'(mag_s5[i]) * DVD_W'(lim_q8);
		end
	end

	// Restoring divider, one quotient bit per stage. The quotient never exceeds
	// the limit, so the upper dividend bits already sit below the divisor.
	for (genvar k = 0; k < Q_W; k++) begin : g_div
		div_t nxt;

		always_comb begin
			logic [MAG_W-1:0] rcur;
			logic [MAG_W:0]   trial;
			nxt = dv_s[k];
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				rcur  = (k == 0) ? dv_s[k].dvd[i][DVD_W-1:Q_W] : dv_s[k].rem[i];
				trial = {rcur, dv_s[k].dvd[i][Q_W-1-k]};
				if (trial >= {1'b0, dv_s[k].top}) begin
					nxt.rem[i]            = MAG_W'(trial - {1'b0, dv_s[k].top});
					nxt.quot[i][Q_W-1-k]  = 1'b1;
				end else begin
					nxt.rem[i]            = MAG_W'(trial);
					nxt.quot[i][Q_W-1-k]  = 1'b0;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[k+1] <= 1'b0;
			else if (ce)
				dv_v_s[k+1] <= dv_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (ce)
				dv_s[k+1] <= nxt;
		end
	end

	// ---------------- s7: final reference, speed error ----------------
	logic                    v_s7, ok_s7;
	logic signed [ERR_W-1:0] err_s7 [WHEEL_COUNT];
	div_t                    dq;

	assign dq = dv_s[Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (ce)
			v_s7 <= dv_v_s[Q_W];
	end

	always_ff @(posedge clk) begin
		logic [MAG_W-1:0]        fm;
		logic signed [REF_W-1:0] rv;
		if (ce) begin
			ok_s7 <= dq.ok;
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				fm = dq.scale ? MAG_W'(dq.quot[i]) : dq.mag[i];
				rv = dq.neg[i] ? -$signed({1'b0, fm}) : $signed({1'b0, fm});
				err_s7[i] <= ERR_W'(rv) - (ERR_W'($signed(dq.meas[i])) <<< 8);
			end
		end
	end

	// ---------------- s8: proportional product ----------------
	logic                   v_s8, ok_s8;
	logic [WHEEL_COUNT-1:0] eneg_s8;
	logic [AERR_W-1:0]      pm_s8 [WHEEL_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (ce)
			v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		logic [AERR_W-1:0] ae;
		logic [PE_W-1:0]   pr;
		if (ce) begin
			ok_s8 <= ok_s7;
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				ae = err_s7[i][ERR_W-1] ? AERR_W'(-err_s7[i]) : AERR_W'(err_s7[i]);
				pr = PE_W'(ae) * PE_W'(prop_gain_q);
				pm_s8[i]   <= pr[PE_W-1:PG_W];
				eneg_s8[i] <= err_s7[i][ERR_W-1];
			end
		end
	end

	// ---------------- output register: clamp, sign, frame ----------------
	logic [CUR_W-1:0] cur_c [WHEEL_COUNT];
	logic             m_valid_q;

	always_comb begin
		logic [14:0] m;
		for (int i = 0; i < WHEEL_COUNT; i++) begin
			m = (pm_s8[i] > AERR_W'(cur_lim_q)) ? cur_lim_q : pm_s8[i][14:0];
			if (!ok_s8)
				cur_c[i] = '0;
			else
				cur_c[i] = eneg_s8[i] ? -{1'b0, m} : {1'b0, m};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (ce)
			m_valid_q <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			m_tdata[15:0]    <= cur_c[0];
			m_tdata[31:16]   <= cur_c[1];
			m_tdata[47:32]   <= cur_c[2];
			m_tdata[63:48]   <= cur_c[3];
			m_tdata[127:64]  <= {cur_c[0], cur_c[1], cur_c[2], cur_c[3]};
			m_tdata[128]     <= !ok_s8;
			m_tdata[135:129] <= '0;
		end
	end

	assign m_tvalid = m_valid_q;

	// ---------------- assertions ----------------
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[128] |-> m_tdata[127:0] == '0)
		else $error("safe stop beat carries nonzero currents");

	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[127:112] == m_tdata[15:0] &&
			m_tdata[79:64] == m_tdata[63:48])
		else $error("command frame does not match currents");

	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:0] != 16'h8000 && m_tdata[63:48] != 16'h8000)
		else $error("current outside symmetric range");

endmodule
`default_nettype wire
